// ===== rtl/tcse_pkg.sv =====
// ----------------------------------------------------------------------------
// tcse_pkg
// Shared types, codes and constants of the time slice executor.
// ----------------------------------------------------------------------------
`default_nettype none

package tcse_pkg;

  // Default sizes of the block.
  localparam int unsigned TCSE_MEM_WORDS = 128;
  localparam int unsigned TCSE_NUM_REGS  = 8;
  localparam int unsigned TCSE_SLICE_LEN = 3;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INSTR_W = 30;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE = 1'b1;
  localparam logic [7:0] SEG_SIZE_RST = 8'd128;

  // Opcodes.
  localparam logic [7:0] OP_ADD  = 8'd0;
  localparam logic [7:0] OP_SUB  = 8'd1;
  localparam logic [7:0] OP_CMP  = 8'd2;
  localparam logic [7:0] OP_IFGT = 8'd3;
  localparam logic [7:0] OP_NOP  = 8'd4;
  localparam logic [7:0] OP_JUMP = 8'd5;
  localparam logic [7:0] OP_HALT = 8'd6;
  localparam logic [7:0] OP_SYSC = 8'd7;

  typedef enum logic [1:0] {
    FUNC_WR_INSTR = 2'd0,
    FUNC_RUN      = 2'd1,
    FUNC_SET_PC   = 2'd2,
    FUNC_SET_REG  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    INT_NONE      = 3'd0,
    INT_SLICE_END = 3'd1,
    INT_SEG_FAULT = 3'd2,
    INT_SVC_CALL  = 3'd3,
    INT_STOPPED   = 3'd4,
    INT_ILLEGAL   = 3'd5
  } int_code_e;

  typedef enum logic [1:0] {
    RSEL_INSTR_I = 2'd0,
    RSEL_INSTR_J = 2'd1,
    RSEL_REQ_I   = 2'd2
  } reg_sel_e;

  // One request word.
  typedef struct packed {
    logic [1:0]         func;
    logic [6:0]         mem_addr;
    logic [7:0]         opcode;
    logic [2:0]         reg_i;
    logic [2:0]         reg_j;
    logic signed [15:0] imm_arg;
    logic signed [31:0] set_value;
  } req_t;

  // One result word.
  typedef struct packed {
    logic [2:0]         int_code;
    logic signed [31:0] pc_out;
    logic signed [31:0] acc_out;
    logic signed [31:0] reg_value;
  } rsp_t;

  // Layout of a stored instruction word.
  typedef struct packed {
    logic signed [15:0] arg;
    logic [2:0]         rj;
    logic [2:0]         ri;
    logic [7:0]         opcode;
  } instr_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_req;
    logic      calc_addr;
    logic      prog_we;
    logic      prog_re;
    logic      reg_re;
    reg_sel_e  reg_sel;
    logic      reg_we_set;
    logic      cap_a;
    logic      exec;
    logic      set_pc;
    logic      set_code;
    int_code_e code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e      func;
    logic       seg_fault;
    logic [7:0] opcode;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/tcse_ram.sv =====
// ----------------------------------------------------------------------------
// tcse_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tcse_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcse_ctrl
// Sequencer that walks a request through address, fetch, decode and execute.
// ----------------------------------------------------------------------------
`default_nettype none

module tcse_ctrl #(
  parameter int unsigned SLICE_LEN = tcse_pkg::TCSE_SLICE_LEN
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  output logic                   done_o,
  input  wire tcse_pkg::dp_sts_t sts_i,
  output tcse_pkg::dp_cmd_t      cmd_o
);

  localparam int unsigned CW = (SLICE_LEN > 1) ? $clog2(SLICE_LEN) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADDR  = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_RDJ   = 4'd4;
  localparam logic [3:0] S_EXEC  = 4'd5;
  localparam logic [3:0] S_MWR   = 4'd6;
  localparam logic [3:0] S_RDOUT = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [3:0]    state_d, state_q;
  logic [CW-1:0] cnt_d, cnt_q;

  always_comb begin
    cmd_o   = '0;
    cmd_o.reg_sel = tcse_pkg::RSEL_REQ_I;
    cmd_o.code    = tcse_pkg::INT_NONE;
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          cnt_d          = '0;
          state_d        = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.calc_addr = 1'b1;
        unique case (sts_i.func)
          tcse_pkg::FUNC_RUN: begin
            if (sts_i.seg_fault) begin
              cmd_o.set_code = 1'b1;
              cmd_o.code     = tcse_pkg::INT_SEG_FAULT;
              state_d        = S_RDOUT;
            end else begin
              state_d = S_FETCH;
            end
          end
          tcse_pkg::FUNC_WR_INSTR: begin
            state_d = S_MWR;
          end
          tcse_pkg::FUNC_SET_PC: begin
            cmd_o.set_pc = 1'b1;
            state_d      = S_RDOUT;
          end
          tcse_pkg::FUNC_SET_REG: begin
            cmd_o.reg_we_set = 1'b1;
            state_d          = S_RDOUT;
          end
        endcase
      end
      S_MWR: begin
        cmd_o.prog_we = 1'b1;
        state_d       = S_RDOUT;
      end
      S_FETCH: begin
        cmd_o.prog_re = 1'b1;
        state_d       = S_DEC;
      end
      S_DEC: begin
        priority if (sts_i.opcode == tcse_pkg::OP_ADD || sts_i.opcode == tcse_pkg::OP_SUB ||
                     sts_i.opcode == tcse_pkg::OP_CMP) begin
          cmd_o.reg_re  = 1'b1;
          cmd_o.reg_sel = tcse_pkg::RSEL_INSTR_I;
          state_d       = S_RDJ;
        end else if (sts_i.opcode == tcse_pkg::OP_IFGT || sts_i.opcode == tcse_pkg::OP_NOP ||
                     sts_i.opcode == tcse_pkg::OP_JUMP ||
                     sts_i.opcode == tcse_pkg::OP_SYSC) begin
          state_d = S_EXEC;
        end else if (sts_i.opcode == tcse_pkg::OP_HALT) begin
          cmd_o.set_code = 1'b1;
          cmd_o.code     = tcse_pkg::INT_STOPPED;
          state_d        = S_RDOUT;
        end else begin
          cmd_o.set_code = 1'b1;
          cmd_o.code     = tcse_pkg::INT_ILLEGAL;
          state_d        = S_RDOUT;
        end
      end
      S_RDJ: begin
        cmd_o.cap_a   = 1'b1;
        cmd_o.reg_re  = 1'b1;
        cmd_o.reg_sel = tcse_pkg::RSEL_INSTR_J;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        priority if (sts_i.opcode == tcse_pkg::OP_SYSC) begin
          cmd_o.set_code = 1'b1;
          cmd_o.code     = tcse_pkg::INT_SVC_CALL;
          state_d        = S_RDOUT;
        end else if (cnt_q == CW'(SLICE_LEN - 1)) begin
          cmd_o.set_code = 1'b1;
          cmd_o.code     = tcse_pkg::INT_SLICE_END;
          state_d        = S_RDOUT;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_ADDR;
        end
      end
      S_RDOUT: begin
        cmd_o.reg_re  = 1'b1;
        cmd_o.reg_sel = tcse_pkg::RSEL_REQ_I;
        state_d       = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("block did not return to idle after a result");

  a_opnd_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap_a |=> cmd_o.exec)
    else $error("operand capture not followed by execute");

  a_prog_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.prog_we && cmd_o.prog_re))
    else $error("program memory written and read in the same cycle");

endmodule

`default_nettype wire

// ===== rtl/tcse_dp.sv =====
// ----------------------------------------------------------------------------
// tcse_dp
// Datapath: request and configuration registers, fetch address reduction,
// program memory, register file and ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module tcse_dp #(
  parameter int unsigned MEM_WORDS = tcse_pkg::TCSE_MEM_WORDS,
  parameter int unsigned NUM_REGS  = tcse_pkg::TCSE_NUM_REGS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tcse_pkg::req_t                     req_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [tcse_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tcse_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire tcse_pkg::dp_cmd_t                  cmd_i,
  output tcse_pkg::dp_sts_t                       sts_o,
  output tcse_pkg::rsp_t                          rsp_o
);

  localparam int unsigned AW     = $clog2(MEM_WORDS);
  localparam int unsigned RIW    = $clog2(NUM_REGS);
  localparam int unsigned SUM_W  = 9;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned RECIP  = (1 << FRAC_W) / MEM_WORDS;
  localparam int unsigned PROD_W = SUM_W + FRAC_W + 1;
  localparam int unsigned QUOT_W = PROD_W - FRAC_W;
  localparam int unsigned REM_W  = 14;
  localparam int unsigned DW     = tcse_pkg::DATA_W;

  // Reduces a three bit register field modulo the register count.
  function automatic logic [4:0] reg_wrap(input logic [2:0] v);
    logic [4:0] r;
    r = {2'b00, v};
    for (int k = 0; k < 4; k++) begin
      if (r >= 5'(NUM_REGS)) begin
        r = r - 5'(NUM_REGS);
      end
    end
    return r;
  endfunction

  tcse_pkg::req_t  req_q;
  logic [6:0]      seg_base_q;
  logic [7:0]      seg_size_q;
  logic [DW-1:0]   pc_q, ac_q, a_q;
  logic [2:0]      code_q;

  logic [SUM_W-1:0]  sum_in, sum_q;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot_q;
  logic [REM_W-1:0]  rem_raw, rem;
  logic [AW-1:0]     word_addr;

  logic [tcse_pkg::INSTR_W-1:0] prog_rdata;
  tcse_pkg::instr_t             instr;

  logic [4:0]          wrap_ii, wrap_ij, wrap_qi;
  logic [RIW-1:0]      reg_raddr, reg_waddr;
  logic                reg_we;
  logic [DW-1:0]       reg_wdata, reg_rdata, reg_rd;
  logic [NUM_REGS-1:0] reg_vld_q;
  logic                rd_vld_q;

  logic [DW-1:0] arg_ext, barg, alu_sum, alu_diff, pc_inc;
  logic          ac_gt;
  logic          is_add, is_sub;

  // Request and configuration registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_base_q <= '0;
      seg_size_q <= tcse_pkg::SEG_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcse_pkg::CFG_SEG_BASE: seg_base_q <= cfg_data_i[6:0];
        tcse_pkg::CFG_SEG_SIZE: seg_size_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Address reduction modulo MEM_WORDS: a reciprocal estimate of the quotient
  // is registered, then the remainder is formed with one correction step.
  always_comb begin
    if (tcse_pkg::func_e'(req_q.func) == tcse_pkg::FUNC_RUN) begin
      sum_in = SUM_W'(seg_base_q) + SUM_W'(pc_q[7:0]);
    end else begin
      sum_in = SUM_W'(req_q.mem_addr);
    end
  end

  assign prod = PROD_W'(sum_in) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_addr) begin
      sum_q  <= sum_in;
      quot_q <= prod[PROD_W-1:FRAC_W];
    end
  end

  assign rem_raw   = REM_W'(sum_q) - REM_W'(quot_q) * REM_W'(MEM_WORDS);
  assign rem       = (rem_raw >= REM_W'(MEM_WORDS)) ? rem_raw - REM_W'(MEM_WORDS) : rem_raw;
  assign word_addr = rem[AW-1:0];

  // Program memory.
  tcse_ram #(
    .WIDTH (tcse_pkg::INSTR_W),
    .DEPTH (MEM_WORDS)
  ) u_prog_mem (
    .clk_i   (clk_i),
    .we_i    (cmd_i.prog_we),
    .waddr_i (word_addr),
    .wdata_i ({req_q.imm_arg, req_q.reg_j, req_q.reg_i, req_q.opcode}),
    .re_i    (cmd_i.prog_re),
    .raddr_i (word_addr),
    .rdata_o (prog_rdata)
  );

  assign instr = tcse_pkg::instr_t'(prog_rdata);

  // Register file with one valid bit per entry; an unwritten entry reads zero.
  assign wrap_ii = reg_wrap(instr.ri);
  assign wrap_ij = reg_wrap(instr.rj);
  assign wrap_qi = reg_wrap(req_q.reg_i);

  always_comb begin
    unique case (cmd_i.reg_sel)
      tcse_pkg::RSEL_INSTR_I: reg_raddr = wrap_ii[RIW-1:0];
      tcse_pkg::RSEL_INSTR_J: reg_raddr = wrap_ij[RIW-1:0];
      default:                reg_raddr = wrap_qi[RIW-1:0];
    endcase
  end

  assign is_add    = (instr.opcode == tcse_pkg::OP_ADD);
  assign is_sub    = (instr.opcode == tcse_pkg::OP_SUB);
  assign reg_we    = (cmd_i.exec && (is_add || is_sub)) || cmd_i.reg_we_set;
  assign reg_waddr = cmd_i.reg_we_set ? wrap_qi[RIW-1:0] : wrap_ii[RIW-1:0];
  assign reg_wdata = cmd_i.reg_we_set ? req_q.set_value : (is_add ? alu_sum : alu_diff);

  tcse_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_REGS)
  ) u_reg_file (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .re_i    (cmd_i.reg_re),
    .raddr_i (reg_raddr),
    .rdata_o (reg_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (reg_we) begin
        reg_vld_q[reg_waddr] <= 1'b1;
      end
      if (cmd_i.reg_re) begin
        rd_vld_q <= reg_vld_q[reg_raddr];
      end
    end
  end

  assign reg_rd = rd_vld_q ? reg_rdata : '0;

  // ALU.
  assign arg_ext  = {{(DW - 16){instr.arg[15]}}, instr.arg};
  assign barg     = reg_rd + arg_ext;
  assign alu_sum  = a_q + barg;
  assign alu_diff = a_q - barg;
  assign pc_inc   = pc_q + DW'(1);
  assign ac_gt    = !ac_q[DW-1] && (ac_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      a_q <= reg_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      ac_q   <= '0;
      code_q <= tcse_pkg::INT_NONE;
    end else begin
      if (cmd_i.load_req) begin
        code_q <= tcse_pkg::INT_NONE;
      end else if (cmd_i.set_code) begin
        code_q <= cmd_i.code;
      end
      if (cmd_i.set_pc) begin
        pc_q <= req_q.set_value;
      end else if (cmd_i.exec) begin
        case (instr.opcode)
          tcse_pkg::OP_ADD: begin
            ac_q <= alu_sum;
            pc_q <= pc_inc;
          end
          tcse_pkg::OP_SUB, tcse_pkg::OP_CMP: begin
            ac_q <= alu_diff;
            pc_q <= pc_inc;
          end
          tcse_pkg::OP_IFGT: begin
            pc_q <= ac_gt ? arg_ext : pc_inc;
          end
          tcse_pkg::OP_JUMP: begin
            pc_q <= arg_ext;
          end
          tcse_pkg::OP_NOP, tcse_pkg::OP_SYSC: begin
            pc_q <= pc_inc;
          end
          default: ;
        endcase
      end
    end
  end

  // Status and result.
  assign sts_o.func      = tcse_pkg::func_e'(req_q.func);
  assign sts_o.seg_fault = pc_q[DW-1] || (pc_q >= DW'(seg_size_q));
  assign sts_o.opcode    = instr.opcode;

  assign rsp_o.int_code  = code_q;
  assign rsp_o.pc_out    = pc_q;
  assign rsp_o.acc_out   = ac_q;
  assign rsp_o.reg_value = reg_rd;

endmodule

`default_nettype wire

// ===== rtl/toy_cpu_time_slice_executor.sv =====
// ----------------------------------------------------------------------------
// toy_cpu_time_slice_executor
// Small accumulator and register CPU that runs one time slice per run request.
// ----------------------------------------------------------------------------
// A request word is taken at a rising edge where start is high and busy is
// low; busy then stays high until the result word has been shown. The result
// word appears on rsp_o for exactly one cycle with done_o high, and the
// receiver cannot hold it off, so it must take every result in that cycle.
// A write of an instruction word passes the address step, the memory
// write, the readout and the result; setting the PC or a data register is
// done in the address step. A run request takes each instruction through
// address, fetch and decode, a second register read for ADD, SUB or CMP,
// and execute; a segment fault, HALT or illegal opcode ends the slice at
// the instruction that raised it. The default slice is three instructions.
// The program memory and the register file each have a single read port,
// so every instruction needs an address step, a fetch step, a decode step
// and one register read per operand before it executes, and the readout
// register is fetched in a step of its own.
// Configuration writes (segment base, segment size) are taken at once and
// must only be issued while the block is idle. The program memory has no
// reset; the data registers, PC and accumulator reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module toy_cpu_time_slice_executor #(
  parameter int unsigned MEM_WORDS = tcse_pkg::TCSE_MEM_WORDS,
  parameter int unsigned NUM_REGS  = tcse_pkg::TCSE_NUM_REGS,
  parameter int unsigned SLICE_LEN = tcse_pkg::TCSE_SLICE_LEN
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Request side.
  input  wire logic                            start,
  output logic                                 busy,
  input  wire tcse_pkg::req_t                  req_i,
  // Result side.
  output logic                                 done_o,
  output tcse_pkg::rsp_t                       rsp_o,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [tcse_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcse_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // The controller sequences each request; the datapath holds all
  // architectural state and the two memories.
  tcse_pkg::dp_cmd_t cmd;
  tcse_pkg::dp_sts_t sts;

  tcse_ctrl #(
    .SLICE_LEN (SLICE_LEN)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  tcse_dp #(
    .MEM_WORDS (MEM_WORDS),
    .NUM_REGS  (NUM_REGS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire
